// ===== hw/rtl/icts_pkg.sv =====
// ----------------------------------------------------------------------------
// icts_pkg
// Shared types and constants of the interface counter text summer.
// ----------------------------------------------------------------------------
package icts_pkg;

   // table layout
   localparam int FIELDS_PER_DIRECTION = 8;
   localparam int HEADER_LINES         = 2;

   // field position stops counting one past the send field
   localparam int POS_LIMIT = FIELDS_PER_DIRECTION + 1;
   localparam int POS_W     = $clog2(POS_LIMIT + 1);
   localparam int HDR_W     = 2;

   // value and total widths
   localparam int VALUE_W = 64;
   localparam int WIDE_W  = VALUE_W + 4;
   localparam int DIGIT_W = 4;

   // classified-byte queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // ASCII codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] receive_total;
      logic [VALUE_W-1:0] send_total;
   } rsp_type;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_SEEK_COLON,
      PHASE_FIELDS
   } phase_type;

   localparam phase_type PHASE_RESET =
      (HEADER_LINES == 0) ? PHASE_SEEK_COLON : PHASE_HEADER;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_DIGIT,
      OP_OTHER,
      OP_SPACE,
      OP_NEWLINE
   } op_type;

   // one classified byte
   typedef struct packed {
      op_type             op;
      logic [DIGIT_W-1:0] digit;
      logic               final_byte;
   } cls_type;

   // one event per scanned byte, with any closed field headed for the totals
   typedef struct packed {
      logic               add_rx;
      logic               add_tx;
      logic               final_byte;
      logic [VALUE_W-1:0] value;
   } event_type;

endpackage

// ===== hw/rtl/iface_counter_text_summer.sv =====
// ----------------------------------------------------------------------------
// iface_counter_text_summer
// Sums receive and send byte counters of a statistics text table.
// ----------------------------------------------------------------------------
//  channel   ports                          payload
//  input     req_push, req_full, req_data   text_byte, end_of_text
//  result    rsp_pop, rsp_empty, rsp_data   receive_total, send_total
//
//  One byte is taken per clock while req_full is low; the field scan in the
//  back part handles one classified byte per cycle while its event stage moves.
//  A result passes the event register and the result register to rsp_data.
//  Reset is synchronous and clears phases, queue, field state and totals.
//  A result that waits for pop stalls only the last-byte event; the queue
//  between front and back absorbs bytes until it fills, then full rises.
// ----------------------------------------------------------------------------
module iface_counter_text_summer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  icts_pkg::req_type req_data,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output icts_pkg::rsp_type rsp_data
);

   icts_pkg::cls_type cls_push, cls_head;
   logic              accept;
   logic              q_empty, q_pop;

   assign accept = req_push && !req_full;

   // classify bytes
   icts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cls_data (cls_push)
   );

   // decouple front and back
   icts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (cls_push),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (cls_head),
      .empty     (q_empty)
   );

   // scan fields and keep totals
   icts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_data  (cls_head),
      .cls_empty (q_empty),
      .cls_pop   (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

// ===== hw/rtl/icts_front.sv =====
// ----------------------------------------------------------------------------
// icts_front
// Tracks header and colon phases and classifies each accepted byte.
// ----------------------------------------------------------------------------
module icts_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  icts_pkg::req_type req_data,
   output icts_pkg::cls_type cls_data
);

   icts_pkg::phase_type          phase_ff, phase_in;
   logic [icts_pkg::HDR_W-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [icts_pkg::HDR_W:0]     hdr_next;
   logic                         is_digit;
   logic [icts_pkg::DIGIT_W-1:0] digit_byte;

   // classify the byte itself
   assign is_digit   = (req_data.text_byte >= icts_pkg::CHAR_ZERO) &&
                       (req_data.text_byte <= icts_pkg::CHAR_NINE);
   assign digit_byte = icts_pkg::DIGIT_W'(req_data.text_byte - icts_pkg::CHAR_ZERO);
   assign hdr_next   = {1'b0, hdr_cnt_ff} + {{icts_pkg::HDR_W{1'b0}}, 1'b1};

   // hold phase and header count
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= icts_pkg::PHASE_RESET;
         hdr_cnt_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
      end
   end

   // next phase and the op for the back part
   always_comb begin
      phase_in            = phase_ff;
      hdr_cnt_in          = hdr_cnt_ff;
      cls_data.op         = icts_pkg::OP_NONE;
      cls_data.digit      = digit_byte;
      cls_data.final_byte = req_data.end_of_text;
      unique case (phase_ff)
         icts_pkg::PHASE_HEADER: begin
            if (req_data.text_byte == icts_pkg::CHAR_NEWLINE) begin
               hdr_cnt_in = hdr_next[icts_pkg::HDR_W-1:0];
               if (hdr_next >= (icts_pkg::HDR_W+1)'(icts_pkg::HEADER_LINES)) begin
                  phase_in = icts_pkg::PHASE_SEEK_COLON;
               end
            end
         end
         icts_pkg::PHASE_SEEK_COLON: begin
            if (req_data.text_byte == icts_pkg::CHAR_COLON) begin
               phase_in    = icts_pkg::PHASE_FIELDS;
               cls_data.op = icts_pkg::OP_START;
            end
         end
         icts_pkg::PHASE_FIELDS: begin
            if (req_data.text_byte == icts_pkg::CHAR_NEWLINE) begin
               phase_in    = icts_pkg::PHASE_SEEK_COLON;
               cls_data.op = icts_pkg::OP_NEWLINE;
            end else if (req_data.text_byte == icts_pkg::CHAR_SPACE) begin
               cls_data.op = icts_pkg::OP_SPACE;
            end else if (is_digit) begin
               cls_data.op = icts_pkg::OP_DIGIT;
            end else begin
               cls_data.op = icts_pkg::OP_OTHER;
            end
         end
         default: begin
            phase_in = icts_pkg::PHASE_RESET;
         end
      endcase
      // drop back to the start of a new table after the last byte
      if (req_data.end_of_text) begin
         phase_in   = icts_pkg::PHASE_RESET;
         hdr_cnt_in = '0;
      end
   end

endmodule

// ===== hw/rtl/icts_queue.sv =====
// ----------------------------------------------------------------------------
// icts_queue
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module icts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  icts_pkg::cls_type push_data,
   output logic              full,
   input  logic              pop,
   output icts_pkg::cls_type pop_data,
   output logic              empty
);

   icts_pkg::cls_type               entry_ff [icts_pkg::QUEUE_DEPTH];
   logic [icts_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [icts_pkg::QCNT_W-1:0]     count_ff;
   logic                            do_push, do_pop;

   assign full     = (count_ff == icts_pkg::QCNT_W'(icts_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // store an entry on each push transfer
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + icts_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + icts_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + icts_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - icts_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/icts_back.sv =====
// ----------------------------------------------------------------------------
// icts_back
// Builds field values, closes fields into events and keeps the totals.
// ----------------------------------------------------------------------------
module icts_back (
   input  logic              clock,
   input  logic              reset,
   input  icts_pkg::cls_type cls_data,
   input  logic              cls_empty,
   output logic              cls_pop,
   output icts_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   localparam int VW = icts_pkg::VALUE_W;
   localparam int WW = icts_pkg::WIDE_W;
   localparam int PW = icts_pkg::POS_W;

   // field scan state
   logic [PW-1:0]     pos_ff, pos_in, pos_mid;
   logic              inside_ff, inside_in, inside_mid;
   logic              done_ff, done_in, done_mid;
   logic [VW-1:0]     value_ff, value_in, value_mid;
   logic [WW-1:0]     tenfold;
   logic              do_close;

   // event stage
   icts_pkg::event_type ev_ff, ev_in;
   logic                ev_valid_ff;
   logic                ev_take;
   logic                fire;

   // totals and result register
   logic [VW-1:0]       rx_ff, rx_in, tx_ff, tx_in;
   icts_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   logic                out_room;

   assign out_room  = !rsp_valid_ff || rsp_pop;
   assign ev_take   = ev_valid_ff && (!ev_ff.final_byte || out_room);
   assign fire      = !cls_empty && (!ev_valid_ff || ev_take);
   assign cls_pop   = fire;
   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

   // value times ten plus the digit, with carry room for saturation
   assign tenfold = {1'b0, value_ff, 3'b0} + {3'b0, value_ff, 1'b0}
                    + {{(WW-icts_pkg::DIGIT_W){1'b0}}, cls_data.digit};

   // apply the byte, then close the field where needed
   always_comb begin
      pos_mid    = pos_ff;
      inside_mid = inside_ff;
      done_mid   = done_ff;
      value_mid  = value_ff;
      case (cls_data.op)
         icts_pkg::OP_START: begin
            pos_mid    = '0;
            inside_mid = 1'b0;
            done_mid   = 1'b0;
            value_mid  = '0;
         end
         icts_pkg::OP_DIGIT: begin
            inside_mid = 1'b1;
            if (!done_ff) begin
               value_mid = (tenfold[WW-1:VW] != '0) ? {VW{1'b1}} : tenfold[VW-1:0];
            end
         end
         icts_pkg::OP_OTHER: begin
            inside_mid = 1'b1;
            done_mid   = 1'b1;
         end
         default: begin
         end
      endcase

      do_close = (cls_data.op inside {icts_pkg::OP_SPACE, icts_pkg::OP_NEWLINE}) ||
                 cls_data.final_byte;

      ev_in.add_rx     = do_close && inside_mid && (pos_mid == '0);
      ev_in.add_tx     = do_close && inside_mid &&
                         (pos_mid == PW'(icts_pkg::FIELDS_PER_DIRECTION));
      ev_in.final_byte = cls_data.final_byte;
      ev_in.value      = value_mid;

      pos_in    = pos_mid;
      inside_in = inside_mid;
      done_in   = done_mid;
      value_in  = value_mid;
      if (do_close) begin
         inside_in = 1'b0;
         done_in   = 1'b0;
         value_in  = '0;
         if ((cls_data.op == icts_pkg::OP_NEWLINE) || cls_data.final_byte) begin
            pos_in = '0;
         end else if (inside_mid && (pos_mid < PW'(icts_pkg::POS_LIMIT))) begin
            pos_in = pos_mid + PW'(1);
         end
      end
   end

   // hold scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         inside_ff <= 1'b0;
         done_ff   <= 1'b0;
         value_ff  <= '0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         inside_ff <= inside_in;
         done_ff   <= done_in;
         value_ff  <= value_in;
      end
   end

   // advance the event stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else if (fire) begin
         ev_valid_ff <= 1'b1;
      end else if (ev_take) begin
         ev_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ev_ff <= ev_in;
      end
   end

   // add closed fields into the totals, and clear them after the last byte
   assign rx_in = rx_ff + (ev_ff.add_rx ? ev_ff.value : '0);
   assign tx_in = tx_ff + (ev_ff.add_tx ? ev_ff.value : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= '0;
         tx_ff <= '0;
      end else if (ev_take) begin
         if (ev_ff.final_byte) begin
            rx_ff <= '0;
            tx_ff <= '0;
         end else begin
            rx_ff <= rx_in;
            tx_ff <= tx_in;
         end
      end
   end

   // load the result register on the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ev_take && ev_ff.final_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_take && ev_ff.final_byte) begin
         rsp_ff.receive_total <= rx_in;
         rsp_ff.send_total    <= tx_in;
      end
   end

endmodule
